// ===== src/htw_pkg.sv =====
`timescale 1ns / 1ps
package htw_pkg;
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_ADDED   = 3'd0,
		K_FULL    = 3'd1,
		K_CANCEL  = 3'd2,
		K_IGNORED = 3'd3,
		K_EXPIRED = 3'd4,
		K_IDLE    = 3'd5
	} kind_t;

	localparam int ID_W  = 6;
	localparam int ROT_W = 24;
	localparam int TO_W  = 32;

	typedef struct packed {
		logic [2:0]      kind;
		logic [ID_W-1:0] entry;
		logic            last;
	} res_t;
endpackage

// ===== src/htw_out_reg.sv =====
`timescale 1ns / 1ps
module htw_out_reg
	import htw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic full,
	output logic m_tvalid,
	input  logic m_tready,
	output res_t m_res
);
	logic valid_q;
	res_t res_q;

	// hold one result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= push_res;
		end
	end

	assign full     = valid_q && !m_tready;
	assign m_tvalid = valid_q;
	assign m_res    = res_q;

	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into stalled output");
	a_valid_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> valid_q) else $error("pushed result lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !m_tready) |=> (valid_q && $stable(res_q)))
		else $error("stalled result changed");
endmodule

// ===== src/hashed_timing_wheel.sv =====
`timescale 1ns / 1ps
// Hashed timing wheel over a fixed pool of timer entries.
// s_axis carries one command per item: tdata = operation, timeout, timer_id from
// the lowest bit up; operation 0 adds a timer, 1 cancels one, 2 advances one tick.
// m_axis carries results: tuser = kind, tdata = entry, tlast marks the final
// result of one input item. Every input item gives at least one result.
// One item is worked on at a time; s_axis_tready is high only while idle.
// An add and a live cancel read and write the memories before their result is
// pushed; pool full, an ignored cancel and the unused code go straight to it.
// A tick walks the current slot's list, counting down entries that only rotate
// and unlinking those that expire; each step reads the entry memories and writes
// back. Expiries come out as the walk goes, the final result at the end of it.
// The next item is taken in the cycle after the final result is pushed.
// Slot heads live in a SLOTS-deep memory (SLOTS must be a power of two); entry
// links, rotation and slot live in POOL_SIZE-deep memories.
// After reset the block sweeps the slot heads to null, one slot a cycle, and
// takes no item until done. Live bits and the current slot clear at once. When
// the receiver stalls, one result waits in the output register and the walk
// holds before each further result until it is taken; none is lost.
module hashed_timing_wheel
	import htw_pkg::*;
#(
	parameter int SLOTS     = 256,
	parameter int POOL_SIZE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // operation[1:0], timeout[33:2], timer_id[39:34]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // entry[5:0], zeros above
	output logic [2:0]  m_axis_tuser,  // kind[2:0]
	output logic        m_axis_tlast
);
	localparam int SW = $clog2(SLOTS);
	localparam int PW = $clog2(POOL_SIZE + 1);   // link width, null = POOL_SIZE
	localparam int EW = $clog2(POOL_SIZE);
	localparam logic [PW-1:0] NIL = PW'(POOL_SIZE);
	localparam logic [TO_W-1:0] ROT_MAX = TO_W'(2**ROT_W - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ADD_WR, S_ADD_FIX, S_CAN_RD, S_CAN_FIX,
		S_TK_HEAD, S_TK_RD, S_TK_DO, S_TK_FIX, S_TK_END, S_EMIT
	} state_t;

	state_t state_q;
	logic [SW-1:0] clr_q, cur_q, slot_q;
	logic [POOL_SIZE-1:0] live_q;
	logic [PW-1:0] walk_q, nx_q, pv_q;
	logic [EW-1:0] ent_q, pend_id_q;
	logic [ROT_W-1:0] rot_q;
	logic pend_q;
	res_t emit_q;

	// memories
	logic [PW-1:0]    head_mem [SLOTS];
	logic [PW-1:0]    next_mem [POOL_SIZE];
	logic [PW-1:0]    prev_mem [POOL_SIZE];
	logic [ROT_W-1:0] rot_mem  [POOL_SIZE];
	logic [SW-1:0]    slot_mem [POOL_SIZE];

	logic          hd_we;
	logic [SW-1:0] hd_addr;
	logic [PW-1:0] hd_wd, hd_rd_q;
	logic          e_re;
	logic [EW-1:0] e_addr;
	logic [PW-1:0] nx_rd_q, pv_rd_q;
	logic [ROT_W-1:0] rot_rd_q;
	logic [SW-1:0] sl_rd_q;

	always_ff @(posedge clk) begin
		if (hd_we) begin
			head_mem[hd_addr] <= hd_wd;
		end
		hd_rd_q <= head_mem[hd_addr];
	end

	always_ff @(posedge clk) begin
		if (e_re) begin
			nx_rd_q  <= next_mem[e_addr];
			pv_rd_q  <= prev_mem[e_addr];
			rot_rd_q <= rot_mem[e_addr];
			sl_rd_q  <= slot_mem[e_addr];
		end
	end

	// write ports: one write each per cycle
	logic nx_we, pv_we, rot_we, sl_we;
	logic [EW-1:0] nx_wa, pv_wa, rot_wa, sl_wa;
	logic [PW-1:0] nx_wd, pv_wd;
	logic [ROT_W-1:0] rot_wd;
	logic [SW-1:0] sl_wd;

	always_ff @(posedge clk) begin
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		if (pv_we) prev_mem[pv_wa] <= pv_wd;
		if (rot_we) rot_mem[rot_wa] <= rot_wd;
		if (sl_we) slot_mem[sl_wa] <= sl_wd;
	end

	// input fields
	logic [1:0]      in_op;
	logic [TO_W-1:0] in_to;
	logic [ID_W-1:0] in_id;
	assign in_op = s_axis_tdata[1:0];
	assign in_to = s_axis_tdata[33:2];
	assign in_id = s_axis_tdata[39:34];

	// rotation is the tick count above the slot bits, slot wraps with the sum
	logic [TO_W-1:0]  ticks;
	logic [TO_W-1:0]  rot_full;
	logic [ROT_W-1:0] add_rot;
	logic [SW-1:0]    add_slot;
	assign ticks    = (in_to == '0) ? TO_W'(1) : in_to;
	assign rot_full = ticks >> SW;
	assign add_rot  = (rot_full > ROT_MAX) ? {ROT_W{1'b1}} : rot_full[ROT_W-1:0];
	assign add_slot = cur_q + ticks[SW-1:0];

	logic cancel_ok;
	assign cancel_ok = ({1'b0, in_id} < (ID_W+1)'(POOL_SIZE)) && live_q[in_id[EW-1:0]];

	// lowest free entry
	logic          free_any;
	logic [EW-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_any = 1'b1;
				free_idx = EW'(i);
			end
		end
	end

	// output register
	logic push, out_full;
	res_t push_res, m_res;
	htw_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .push(push), .push_res(push_res),
		.full(out_full), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.m_res(m_res)
	);
	assign m_axis_tdata = 8'(m_res.entry);
	assign m_axis_tuser = m_res.kind;
	assign m_axis_tlast = m_res.last;

	logic accept;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	// memory control and result push
	always_comb begin
		hd_we = 1'b0; hd_addr = cur_q; hd_wd = NIL;
		e_re = 1'b0; e_addr = walk_q[EW-1:0];
		nx_we = 1'b0; nx_wa = ent_q; nx_wd = nx_q;
		pv_we = 1'b0; pv_wa = ent_q; pv_wd = NIL;
		rot_we = 1'b0; rot_wa = ent_q; rot_wd = rot_q;
		sl_we = 1'b0; sl_wa = ent_q; sl_wd = slot_q;
		push = 1'b0;
		push_res = emit_q;
		unique case (state_q)
			S_CLEAR: begin
				hd_we = 1'b1; hd_addr = clr_q;
			end
			S_IDLE: begin
				// start the read the item needs next cycle; a tick reads the current head
				if (in_op == OP_ADD) hd_addr = add_slot;
				if (in_op == OP_CANCEL) begin
					e_re = 1'b1; e_addr = in_id[EW-1:0];
				end
			end
			S_ADD_WR: begin
				// new entry becomes the head of its slot
				hd_we = 1'b1; hd_addr = slot_q; hd_wd = PW'(ent_q);
				nx_we = 1'b1; nx_wd = hd_rd_q;
				pv_we = 1'b1;
				rot_we = 1'b1; sl_we = 1'b1;
			end
			S_ADD_FIX: begin
				if (nx_q != NIL) begin
					pv_we = 1'b1; pv_wa = nx_q[EW-1:0]; pv_wd = PW'(ent_q);
				end
			end
			S_CAN_FIX, S_TK_FIX: begin
				// unlink: point the neighbors past the entry
				if (pv_q != NIL) begin
					nx_we = 1'b1; nx_wa = pv_q[EW-1:0];
				end else begin
					hd_we = 1'b1; hd_addr = slot_q; hd_wd = nx_q;
				end
				if (nx_q != NIL) begin
					pv_we = 1'b1; pv_wa = nx_q[EW-1:0]; pv_wd = pv_q;
				end
				// a further expiry releases the one held back
				if (state_q == S_TK_FIX && pend_q) begin
					push = !out_full;
					push_res = '{kind: K_EXPIRED, entry: ID_W'(pend_id_q), last: 1'b0};
				end
			end
			S_TK_RD: e_re = (walk_q != NIL);
			S_TK_DO: begin
				if (rot_rd_q != '0) begin
					rot_we = 1'b1; rot_wa = walk_q[EW-1:0];
					rot_wd = rot_rd_q - ROT_W'(1);
				end
			end
			S_TK_END: begin
				push = !out_full;
				if (pend_q) begin
					push_res = '{kind: K_EXPIRED, entry: ID_W'(pend_id_q), last: 1'b1};
				end else begin
					push_res = '{kind: K_IDLE, entry: ID_W'(0), last: 1'b1};
				end
			end
			S_EMIT: push = !out_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			cur_q     <= '0;
			slot_q    <= '0;
			live_q    <= '0;
			walk_q    <= NIL;
			nx_q      <= NIL;
			pv_q      <= NIL;
			ent_q     <= '0;
			pend_id_q <= '0;
			rot_q     <= '0;
			pend_q    <= 1'b0;
			emit_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						unique case (op_t'(in_op))
							OP_ADD: begin
								ent_q  <= free_idx;
								slot_q <= add_slot;
								rot_q  <= add_rot;
								if (free_any) begin
									state_q <= S_ADD_WR;
								end else begin
									emit_q  <= '{kind: K_FULL, entry: ID_W'(0), last: 1'b1};
									state_q <= S_EMIT;
								end
							end
							OP_CANCEL: begin
								ent_q <= in_id[EW-1:0];
								if (cancel_ok) begin
									state_q <= S_CAN_RD;
								end else begin
									emit_q  <= '{kind: K_IGNORED, entry: in_id, last: 1'b1};
									state_q <= S_EMIT;
								end
							end
							OP_TICK: begin
								slot_q  <= cur_q;
								pend_q  <= 1'b0;
								state_q <= S_TK_HEAD;
							end
							OP_NONE: begin
								emit_q  <= '{kind: K_IDLE, entry: ID_W'(0), last: 1'b1};
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_ADD_WR: begin
					nx_q    <= hd_rd_q;
					state_q <= S_ADD_FIX;
				end
				S_ADD_FIX: begin
					live_q[ent_q] <= 1'b1;
					emit_q  <= '{kind: K_ADDED, entry: ID_W'(ent_q), last: 1'b1};
					state_q <= S_EMIT;
				end
				S_CAN_RD: begin
					nx_q    <= nx_rd_q;
					pv_q    <= pv_rd_q;
					slot_q  <= sl_rd_q;
					live_q[ent_q] <= 1'b0;
					emit_q  <= '{kind: K_CANCEL, entry: ID_W'(ent_q), last: 1'b1};
					state_q <= S_CAN_FIX;
				end
				S_CAN_FIX: state_q <= S_EMIT;
				S_TK_HEAD: begin
					walk_q  <= hd_rd_q;
					state_q <= S_TK_RD;
				end
				S_TK_RD: begin
					if (walk_q == NIL) begin
						state_q <= S_TK_END;
					end else begin
						state_q <= S_TK_DO;
					end
				end
				S_TK_DO: begin
					nx_q <= nx_rd_q;
					pv_q <= pv_rd_q;
					if (rot_rd_q != '0) begin
						walk_q  <= nx_rd_q;
						state_q <= S_TK_RD;
					end else begin
						live_q[walk_q[EW-1:0]] <= 1'b0;
						ent_q   <= walk_q[EW-1:0];
						state_q <= S_TK_FIX;
					end
				end
				S_TK_FIX: begin
					// hold the expiry back until it is known whether more follow
					if (!pend_q || !out_full) begin
						pend_q    <= 1'b1;
						pend_id_q <= ent_q;
						walk_q    <= nx_q;
						state_q   <= S_TK_RD;
					end
				end
				S_TK_END: begin
					if (!out_full) begin
						pend_q  <= 1'b0;
						cur_q   <= cur_q + SW'(1);
						state_q <= S_IDLE;
					end
				end
				S_EMIT: if (!out_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_walk_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TK_DO) |-> (walk_q != NIL)) else $error("walk past list end");
	a_add_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD_WR) |-> !live_q[ent_q]) else $error("add onto live entry");
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == K_IDLE) |-> m_axis_tlast)
		else $error("idle result without last");
endmodule

// ===== tb/tb_hashed_timing_wheel.sv =====
`timescale 1ns / 1ps
module tb_hashed_timing_wheel;
	import htw_pkg::*;

	localparam int SLOTS     = 256;
	localparam int POOL_SIZE = 64;
	localparam int NIL       = POOL_SIZE;
	localparam int ROT_MAX   = 24'hFFFFFF;
	localparam int N_RANDOM  = 380;

	typedef struct {
		op_t         op;
		logic [31:0] timeout;
		logic [5:0]  timer_id;
	} wheel_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	hashed_timing_wheel uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Shadow wheel state
	int          head_of[SLOTS];
	int          link_next[POOL_SIZE];
	int          link_prev[POOL_SIZE];
	int          rot_left[POOL_SIZE];
	int          home_slot[POOL_SIZE];
	bit          busy[POOL_SIZE];
	int          now_slot;

	wheel_cmd_t  cmd_queue[$];
	res_t        wheel_results[$];
	int          mismatches;
	int          results_seen;
	int          expiries_seen;
	int          hold_gap;
	int          stall_gap;
	bit          sender_hold;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Pick a gap: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void emit_result(logic [2:0] k, int e, ref res_t got[$]);
		res_t r;
		r.kind  = k;
		r.entry = e[5:0];
		r.last  = 1'b0;
		got.push_back(r);
	endfunction

	function automatic void drop_link(int e);
		if (link_prev[e] < POOL_SIZE) link_next[link_prev[e]] = link_next[e];
		else head_of[home_slot[e]] = link_next[e];
		if (link_next[e] < POOL_SIZE) link_prev[link_next[e]] = link_prev[e];
		busy[e] = 1'b0;
	endfunction

	// Apply one command to the shadow wheel and queue its results.
	function automatic void predict_wheel(wheel_cmd_t c);
		res_t got[$];
		int e, cur, nx, guard;
		logic [31:0] ticks, rot;
		case (c.op)
			OP_ADD: begin
				e = 0;
				while (e < POOL_SIZE && busy[e]) e++;
				if (e >= POOL_SIZE) begin
					emit_result(K_FULL, 0, got);
				end else begin
					ticks = (c.timeout == 0) ? 32'd1 : c.timeout;
					rot = ticks / SLOTS;
					if (rot > ROT_MAX) rot = ROT_MAX;
					rot_left[e]  = rot;
					home_slot[e] = (now_slot + ticks % SLOTS) % SLOTS;
					link_prev[e] = NIL;
					link_next[e] = head_of[home_slot[e]];
					if (link_next[e] < POOL_SIZE) link_prev[link_next[e]] = e;
					head_of[home_slot[e]] = e;
					busy[e] = 1'b1;
					emit_result(K_ADDED, e, got);
				end
			end
			OP_CANCEL: begin
				if (busy[c.timer_id]) begin
					drop_link(c.timer_id);
					emit_result(K_CANCEL, c.timer_id, got);
				end else begin
					emit_result(K_IGNORED, c.timer_id, got);
				end
			end
			OP_TICK: begin
				cur = head_of[now_slot];
				guard = 0;
				while (cur < POOL_SIZE && guard < POOL_SIZE) begin
					nx = link_next[cur];
					guard++;
					if (rot_left[cur] > 0) begin
						rot_left[cur]--;
					end else begin
						drop_link(cur);
						emit_result(K_EXPIRED, cur, got);
					end
					cur = nx;
				end
				if (got.size() == 0) emit_result(K_IDLE, 0, got);
				now_slot = (now_slot + 1) % SLOTS;
			end
			default: emit_result(K_IDLE, 0, got);
		endcase
		got[got.size()-1].last = 1'b1;
		foreach (got[i]) wheel_results.push_back(got[i]);
	endfunction

	function automatic wheel_cmd_t make_cmd(op_t op, logic [31:0] to, logic [5:0] id);
		wheel_cmd_t c;
		c.op = op;
		c.timeout = to;
		c.timer_id = id;
		return c;
	endfunction

	// Random timeout: mostly near-term so timers expire within the run.
	function automatic logic [31:0] rand_timeout();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 20);
		if (r < 85) return $urandom_range(250, 600);
		return $urandom();
	endfunction

	// Driver: pop the next item when the bus is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			hold_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_wheel(make_cmd(op_t'(s_axis_tdata[1:0]), s_axis_tdata[33:2],
					s_axis_tdata[39:34]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (hold_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					hold_gap <= hold_gap - 1;
				end else if (cmd_queue.size() > 0 && !sender_hold) begin
					wheel_cmd_t c;
					c = cmd_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {c.timer_id, c.timeout, c.op};
					hold_gap <= pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_gap     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (wheel_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result tuser=%h tdata=%h tlast=%b",
							m_axis_tuser, m_axis_tdata, m_axis_tlast);
				end else begin
					res_t w;
					w = wheel_results.pop_front();
					if (w.kind == K_EXPIRED) expiries_seen++;
					if (m_axis_tuser !== w.kind || m_axis_tdata[5:0] !== w.entry
						|| m_axis_tdata[7:6] !== 2'd0 || m_axis_tlast !== w.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp kind=%0d entry=%0d last=%b, %s%0d %s%0d %s%b",
								w.kind, w.entry, w.last, "got kind=", m_axis_tuser,
								"entry=", m_axis_tdata[5:0], "last=", m_axis_tlast);
					end
				end
			end
			if (stall_gap > 0) begin
				m_axis_tready <= 1'b0;
				stall_gap <= stall_gap - 1;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall_gap <= pick_gap();
			end
		end
	end

	initial begin
		int op_pick;
		arst_n = 1'b0;
		sender_hold = 1'b0;
		mismatches = 0;
		results_seen = 0;
		expiries_seen = 0;
		foreach (head_of[i]) head_of[i] = NIL;
		foreach (busy[i]) begin
			busy[i] = 1'b0;
			link_next[i] = 0; link_prev[i] = 0; rot_left[i] = 0; home_slot[i] = 0;
		end
		now_slot = 0;

		// Directed: zero timeout, extremes, cancel live and dead, idle code, expiry.
		cmd_queue.push_back(make_cmd(OP_TICK, 0, 0));
		cmd_queue.push_back(make_cmd(OP_ADD, 32'd0, 6'd0));
		cmd_queue.push_back(make_cmd(OP_ADD, 32'hFFFFFFFF, 6'h3F));
		cmd_queue.push_back(make_cmd(OP_ADD, 32'd256, 0));
		cmd_queue.push_back(make_cmd(OP_ADD, 32'd1, 0));
		cmd_queue.push_back(make_cmd(OP_CANCEL, 0, 6'd1));
		cmd_queue.push_back(make_cmd(OP_CANCEL, 0, 6'd1));
		cmd_queue.push_back(make_cmd(OP_CANCEL, 32'hFFFFFFFF, 6'h3F));
		cmd_queue.push_back(make_cmd(OP_NONE, 32'hAAAAAAAA, 6'h2A));
		cmd_queue.push_back(make_cmd(OP_TICK, 32'h55555555, 6'h15));
		cmd_queue.push_back(make_cmd(OP_TICK, 0, 0));
		// Fill the pool to see the full answer, then drain the near slots.
		for (int i = 0; i < 66; i++)
			cmd_queue.push_back(make_cmd(OP_ADD, $urandom_range(1, 3), 0));
		for (int i = 0; i < 4; i++) cmd_queue.push_back(make_cmd(OP_TICK, 0, 0));

		#24 arst_n = 1'b1;

		// Pause the sender until everything so far has come back.
		wait (cmd_queue.size() == 0);
		@(posedge clk);
		sender_hold = 1'b1;
		while (wheel_results.size() != 0 || s_axis_tvalid) @(posedge clk);
		sender_hold = 1'b0;

		for (int i = 0; i < N_RANDOM; i++) begin
			op_pick = $urandom_range(0, 99);
			if (op_pick < 40)
				cmd_queue.push_back(make_cmd(OP_ADD, rand_timeout(), 6'($urandom())));
			else if (op_pick < 55)
				cmd_queue.push_back(make_cmd(OP_CANCEL, $urandom(), 6'($urandom())));
			else if (op_pick < 97)
				cmd_queue.push_back(make_cmd(OP_TICK, $urandom(), 6'($urandom())));
			else
				cmd_queue.push_back(make_cmd(OP_NONE, $urandom(), 6'($urandom())));
			if (cmd_queue.size() > 8) wait (cmd_queue.size() <= 8);
		end
		wait (cmd_queue.size() == 0);
		while (s_axis_tvalid || wheel_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		$display("Checked %0d results with %0d expiries over adds, cancels and ticks,",
			results_seen, expiries_seen);
		$display("including a full pool, zero and huge timeouts and the unused code.");
		if (mismatches == 0 && wheel_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results left over", mismatches,
				wheel_results.size());
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("timeout");
		$display("FAILURE");
		$finish;
	end
endmodule
